FILE: rtl/core/prw_pkg.sv
package prw_pkg;

    localparam int MAX_RANGES = 16;
    localparam int OFF_W      = 63;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [OFF_W-1:0] TOP_OFFSET = {OFF_W{1'b1}};

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_COMP  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    typedef enum logic [2:0] {
        STAT_ADDED   = 3'd0,
        STAT_INVALID = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_ALLOWED = 3'd3,
        STAT_DENIED  = 3'd4
    } status_t;

    // Lookup token walking down the cell chain
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [OFF_W-1:0] off;
    } prw_tok_t;

    // Entry load broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] idx;
        logic [OFF_W-1:0] lo;
        logic [OFF_W-1:0] hi;
    } prw_wr_t;

endpackage

FILE: rtl/core/protected_range_write_checker.sv
// Write-protect checker for a block store.
//
// Requests: an item is taken at a rising edge with start high and busy low.
// cmd 0 loads one inclusive byte range, cmd 1 loads the complement of a range
// (up to two entries), cmd 2 checks one byte of a write request.
// Results: done is high for exactly one cycle with status and bad_offset;
// the receiver cannot stall, so a result is never held back.
// Per command:
//   add range          result in the next cycle, next request at once.
//   complement (2 ent) result in the next cycle, busy while S_LOAD_HI loads entry 2.
//   check byte         when the byte changes, the table is not empty and
//                      the request is not yet denied, a lookup token walks
//                      the row of MAX_RANGES range cells, one cell per cycle;
//                      busy till it leaves the last cell, then result (on last).
//                      Else result (on last) next cycle, next request at once.
// The cell chain length sets the check latency.
// Reset clears the range count, the pending verdict and the output strobe;
// range entries themselves are not cleared, they are masked by the count.
module protected_range_write_checker
    import prw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       cmd,
    input  logic [OFF_W-1:0] range_start,
    input  logic [OFF_W-1:0] range_end,
    input  logic [OFF_W-1:0] offset,
    input  logic [7:0]       new_byte,
    input  logic [7:0]       old_byte,
    input  logic             zeroing,
    input  logic             last,
    output logic             done,
    output logic [2:0]       status,
    output logic [OFF_W-1:0] bad_offset
);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_SCAN    = 3'b010,
        S_LOAD_HI = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             denied_reg, denied_next;
    logic [OFF_W-1:0] first_bad_reg, first_bad_next;
    logic             last_pend_reg, last_pend_next;
    logic [OFF_W-1:0] hi_pend_reg, hi_pend_next;
    logic             done_reg, done_next;
    status_t          status_reg, status_next;
    logic [OFF_W-1:0] bad_reg, bad_next;

    prw_wr_t          wr;
    prw_tok_t         tok_head;
    prw_tok_t         tok_tail;
    prw_tok_t         tok [0:MAX_RANGES];

    logic             accept;
    logic             want_low;
    logic             want_high;
    logic             inverted;
    logic [1:0]       need;
    logic [CNT_W:0]   count_ext;
    logic             full_one;
    logic             full_comp;
    logic             changes;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign want_low  = (range_start != '0);
    assign want_high = (range_end != TOP_OFFSET);
    assign inverted  = (range_end < range_start);
    assign need      = {1'b0, want_low} + {1'b0, want_high};
    assign count_ext = {1'b0, count_reg};
    assign full_one  = count_ext >= (CNT_W+1)'(MAX_RANGES);
    assign full_comp = (count_ext + (CNT_W+1)'(need)) > (CNT_W+1)'(MAX_RANGES);
    assign changes   = zeroing ? (old_byte != 8'd0) : (new_byte != old_byte);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        denied_next    = denied_reg;
        first_bad_next = first_bad_reg;
        last_pend_next = last_pend_reg;
        hi_pend_next   = hi_pend_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        bad_next       = bad_reg;
        wr             = '0;
        tok_head       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            done_next = 1'b1;
                            bad_next  = '0;
                            if (inverted)
                            begin
                                status_next = STAT_INVALID;
                            end
                            else if (full_one)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr.en       = 1'b1;
                                wr.idx      = count_reg;
                                wr.lo       = range_start;
                                wr.hi       = range_end;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = STAT_ADDED;
                            end
                        end
                        CMD_COMP:
                        begin
                            done_next = 1'b1;
                            bad_next  = '0;
                            if (inverted)
                            begin
                                status_next = STAT_INVALID;
                            end
                            else if (full_comp)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_ADDED;
                                if (want_low)
                                begin
                                    wr.en      = 1'b1;
                                    wr.idx     = count_reg;
                                    wr.lo      = '0;
                                    wr.hi      = range_start - OFF_W'(1);
                                    count_next = count_reg + CNT_W'(1);
                                    if (want_high)
                                    begin
                                        // second entry goes in on the next cycle
                                        hi_pend_next = range_end + OFF_W'(1);
                                        state_next   = S_LOAD_HI;
                                    end
                                end
                                else if (want_high)
                                begin
                                    wr.en      = 1'b1;
                                    wr.idx     = count_reg;
                                    wr.lo      = range_end + OFF_W'(1);
                                    wr.hi      = TOP_OFFSET;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        CMD_CHECK:
                        begin
                            if (changes && !denied_reg && (count_reg != '0))
                            begin
                                tok_head.valid = 1'b1;
                                tok_head.hit   = 1'b0;
                                tok_head.off   = offset;
                                last_pend_next = last;
                                state_next     = S_SCAN;
                            end
                            else if (last)
                            begin
                                done_next      = 1'b1;
                                status_next    = denied_reg ? STAT_DENIED : STAT_ALLOWED;
                                bad_next       = denied_reg ? first_bad_reg : '0;
                                denied_next    = 1'b0;
                                first_bad_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            S_LOAD_HI:
            begin
                wr.en      = 1'b1;
                wr.idx     = count_reg;
                wr.lo      = hi_pend_reg;
                wr.hi      = TOP_OFFSET;
                count_next = count_reg + CNT_W'(1);
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (tok_tail.valid)
                begin
                    state_next = S_IDLE;
                    if (last_pend_reg)
                    begin
                        done_next      = 1'b1;
                        denied_next    = 1'b0;
                        first_bad_next = '0;
                        if (tok_tail.hit)
                        begin
                            status_next = STAT_DENIED;
                            bad_next    = tok_tail.off;
                        end
                        else
                        begin
                            status_next = STAT_ALLOWED;
                            bad_next    = '0;
                        end
                    end
                    else if (tok_tail.hit)
                    begin
                        denied_next    = 1'b1;
                        first_bad_next = tok_tail.off;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Token enters at the head of the row and leaves at the tail
    assign tok[0]   = tok_head;
    assign tok_tail = tok[MAX_RANGES];

    // Row of range cells; the lookup token shifts one cell per cycle
    genvar gi;
    generate
        for (gi = 0; gi < MAX_RANGES; gi++)
        begin : g_cell
            prw_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .my_idx      (CNT_W'(gi)),
                .range_count (count_reg),
                .wr          (wr),
                .tok_in      (tok[gi]),
                .tok_out     (tok[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            denied_reg    <= 1'b0;
            first_bad_reg <= '0;
            last_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            denied_reg    <= denied_next;
            first_bad_reg <= first_bad_next;
            last_pend_reg <= last_pend_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_pend_reg <= hi_pend_next;
        status_reg  <= status_next;
        bad_reg     <= bad_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign bad_offset = bad_reg;

endmodule

FILE: rtl/core/prw_cell.sv
module prw_cell
    import prw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] my_idx,
    input  logic [CNT_W-1:0] range_count,
    input  prw_wr_t          wr,
    input  prw_tok_t         tok_in,
    output prw_tok_t         tok_out
);

    logic [OFF_W-1:0] start_reg;
    logic [OFF_W-1:0] end_reg;
    logic             tok_valid_reg;
    logic             tok_hit_reg;
    logic [OFF_W-1:0] tok_off_reg;
    logic             active;
    logic             match;

    // Entries are only ever appended, so a cell is live once below the count
    assign active = my_idx < range_count;
    assign match  = active && (start_reg <= tok_in.off) && (tok_in.off <= end_reg);

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == my_idx))
        begin
            start_reg <= wr.lo;
            end_reg   <= wr.hi;
        end
        tok_hit_reg <= tok_in.hit | match;
        tok_off_reg <= tok_in.off;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.hit   = tok_hit_reg;
    assign tok_out.off   = tok_off_reg;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import prw_pkg::*;

    // Command code the block must ignore (no result, no state change).
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Random part: chunks of about CHUNK_ITEMS requests, drained between chunks
    // so the generator can steer the range table toward its interesting fill levels.
    localparam int N_CHUNKS    = 40;
    localparam int CHUNK_ITEMS = 40;

    // One request as presented on the command ports.
    typedef struct {
        logic [1:0]       op;
        logic [OFF_W-1:0] lo;
        logic [OFF_W-1:0] hi;
        logic [OFF_W-1:0] off;
        logic [7:0]       nb;
        logic [7:0]       ob;
        logic             zero_req;
        logic             is_last;
    } prw_req_t;

    // One result the block owes us.
    typedef struct {
        status_t          st;
        logic [OFF_W-1:0] bad;
    } prw_outcome_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       cmd = CMD_ADD;
    logic [OFF_W-1:0] range_start = '0;
    logic [OFF_W-1:0] range_end = '0;
    logic [OFF_W-1:0] offset = '0;
    logic [7:0]       new_byte = 8'h00;
    logic [7:0]       old_byte = 8'h00;
    logic             zeroing = 1'b0;
    logic             last = 1'b0;
    logic             done;
    logic [2:0]       status;
    logic [OFF_W-1:0] bad_offset;

    protected_range_write_checker uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .range_start (range_start),
        .range_end   (range_end),
        .offset      (offset),
        .new_byte    (new_byte),
        .old_byte    (old_byte),
        .zeroing     (zeroing),
        .last        (last),
        .done        (done),
        .status      (status),
        .bad_offset  (bad_offset)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the protection table and the open write request.
    // ------------------------------------------------------------------
    logic [OFF_W-1:0] prot_lo [MAX_RANGES];
    logic [OFF_W-1:0] prot_hi [MAX_RANGES];
    int               prot_cnt = 0;
    logic             req_bad = 1'b0;
    logic [OFF_W-1:0] req_bad_off = '0;

    prw_outcome_t     outcomes_due [$];
    prw_req_t         pend_q [$];

    // Bookkeeping for the summary and the verdict
    int n_queued   = 0;
    int n_sent     = 0;
    int n_loads    = 0;
    int n_bytes    = 0;
    int n_checked  = 0;
    int n_denied   = 0;
    int n_full     = 0;
    int mismatches = 0;

    // Interesting offsets: range edges and their neighbors, fed by the generator
    logic [OFF_W-1:0] hot_pts [$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic owe(input status_t st, input logic [OFF_W-1:0] bad);
        prw_outcome_t oc;
        oc.st  = st;
        oc.bad = bad;
        outcomes_due.push_back(oc);
        if (st == STAT_DENIED)
            n_denied++;
        if (st == STAT_FULL)
            n_full++;
    endtask

    task automatic store_range(input logic [OFF_W-1:0] lo, input logic [OFF_W-1:0] hi);
        prot_lo[prot_cnt] = lo;
        prot_hi[prot_cnt] = hi;
        prot_cnt++;
    endtask

    // Works out what one accepted request does to the table and the open
    // write, and queues the result it must produce (if any).
    task automatic predict_outcome(input prw_req_t rq);
        logic want_lo;
        logic want_hi;
        int   need;
        logic alters;
        logic hit;
        want_lo = (rq.lo != '0);
        want_hi = (rq.hi != TOP_OFFSET);
        need    = int'(want_lo) + int'(want_hi);
        case (rq.op)
            CMD_ADD:
            begin
                n_loads++;
                if (rq.hi < rq.lo)
                    owe(STAT_INVALID, '0);
                else if (prot_cnt >= MAX_RANGES)
                    owe(STAT_FULL, '0);
                else
                begin
                    store_range(rq.lo, rq.hi);
                    owe(STAT_ADDED, '0);
                end
            end
            CMD_COMP:
            begin
                // complement: [0, lo-1] and [hi+1, TOP], each only if non-empty
                n_loads++;
                if (rq.hi < rq.lo)
                    owe(STAT_INVALID, '0);
                else if (prot_cnt + need > MAX_RANGES)
                    owe(STAT_FULL, '0);
                else
                begin
                    if (want_lo)
                        store_range('0, rq.lo - OFF_W'(1));
                    if (want_hi)
                        store_range(rq.hi + OFF_W'(1), TOP_OFFSET);
                    owe(STAT_ADDED, '0);
                end
            end
            CMD_CHECK:
            begin
                n_bytes++;
                // zeroing compares the stored byte against zero, new_byte is ignored
                alters = rq.zero_req ? (rq.ob != 8'h00) : (rq.nb != rq.ob);
                hit = 1'b0;
                for (int i = 0; i < prot_cnt; i++)
                    if (prot_lo[i] <= rq.off && rq.off <= prot_hi[i])
                        hit = 1'b1;
                // only the first offending byte of a request is remembered
                if (alters && !req_bad && hit)
                begin
                    req_bad     = 1'b1;
                    req_bad_off = rq.off;
                end
                if (rq.is_last)
                begin
                    if (req_bad)
                        owe(STAT_DENIED, req_bad_off);
                    else
                        owe(STAT_ALLOWED, '0);
                    req_bad     = 1'b0;
                    req_bad_off = '0;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: feeds pend_q onto the command ports at the falling edge.
    // A request is held until the rising edge that takes it
    // (start high, busy low); gaps are drawn per request.
    // ------------------------------------------------------------------
    prw_req_t cur;
    logic     armed = 1'b0;
    int       gap_left = 0;
    logic     req_taken = 1'b0;
    logic     idle_on = 1'b0;

    always @(negedge clk)
    begin : drive_requests
        logic slot_free;
        slot_free = !start || req_taken;
        if (rst_n && slot_free)
        begin
            if (!armed && pend_q.size() != 0)
            begin
                cur      = pend_q.pop_front();
                gap_left = idle_on ? int'($urandom_range(0, 5)) : 0;
                armed    = 1'b1;
            end
            if (armed && gap_left == 0)
            begin
                cmd         <= cur.op;
                range_start <= cur.lo;
                range_end   <= cur.hi;
                offset      <= cur.off;
                new_byte    <= cur.nb;
                old_byte    <= cur.ob;
                zeroing     <= cur.zero_req;
                last        <= cur.is_last;
                start       <= 1'b1;
                armed        = 1'b0;
            end
            else
            begin
                start <= 1'b0;
                if (armed)
                    gap_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, check a strobed result against the
    // oldest owed one, then predict for a request taken at this edge.
    // A result is registered, so it never comes at the edge that takes its
    // request, and the order of the two steps does not matter.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_bus
        prw_outcome_t want;
        prw_req_t     seen;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (outcomes_due.size() == 0)
                    report_mismatch($sformatf("result with nothing owed: status %0d off %0h",
                                              status, bad_offset));
                else
                begin
                    want = outcomes_due.pop_front();
                    n_checked++;
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
                    if (bad_offset !== want.bad)
                        report_mismatch($sformatf("bad_offset %0h, expected %0h",
                                                  bad_offset, want.bad));
                end
            end
            req_taken <= start && !busy;
            if (start && !busy)
            begin
                seen.op       = cmd;
                seen.lo       = range_start;
                seen.hi       = range_end;
                seen.off      = offset;
                seen.nb       = new_byte;
                seen.ob       = old_byte;
                seen.zero_req = zeroing;
                seen.is_last  = last;
                predict_outcome(seen);
                n_sent++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [OFF_W-1:0] any_offset();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[OFF_W-1:0];
    endfunction

    function automatic logic [OFF_W-1:0] near_hot();
        logic [OFF_W-1:0] pt;
        if (hot_pts.size() == 0)
            return any_offset();
        pt = hot_pts[$urandom_range(0, hot_pts.size() - 1)];
        return pt - OFF_W'(3) + OFF_W'($urandom_range(0, 6));
    endfunction

    function automatic logic [OFF_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return OFF_W'($urandom_range(0, 1000));
            1:       return TOP_OFFSET - OFF_W'($urandom_range(0, 1000));
            2:       return any_offset();
            default: return near_hot();
        endcase
    endfunction

    task automatic queue_req(input logic [1:0] op, input logic [OFF_W-1:0] lo,
                             input logic [OFF_W-1:0] hi, input logic [OFF_W-1:0] off,
                             input logic [7:0] nb, input logic [7:0] ob,
                             input logic zr, input logic lst);
        prw_req_t rq;
        rq.op       = op;
        rq.lo       = lo;
        rq.hi       = hi;
        rq.off      = off;
        rq.nb       = nb;
        rq.ob       = ob;
        rq.zero_req = zr;
        rq.is_last  = lst;
        pend_q.push_back(rq);
        // ignored commands do not count toward the stimulus volume
        if (op != CMD_UNUSED)
            n_queued++;
    endtask

    // Range load; unused byte fields carry noise.
    task automatic queue_range(input logic [1:0] op, input logic [OFF_W-1:0] lo,
                               input logic [OFF_W-1:0] hi);
        queue_req(op, lo, hi, any_offset(), 8'($urandom), 8'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        hot_pts.push_back(lo - OFF_W'(1));
        hot_pts.push_back(lo);
        hot_pts.push_back(hi);
        hot_pts.push_back(hi + OFF_W'(1));
    endtask

    task automatic queue_byte(input logic [OFF_W-1:0] off, input logic [7:0] nb,
                              input logic [7:0] ob, input logic zr, input logic lst);
        queue_req(CMD_CHECK, any_offset(), any_offset(), off, nb, ob, zr, lst);
    endtask

    // Well-formed write: consecutive bytes, last on the final one.
    task automatic queue_write(input int len);
        logic [OFF_W-1:0] base;
        logic             zr;
        logic [7:0]       nb;
        logic [7:0]       ob;
        base = ($urandom_range(0, 9) < 7) ? near_hot() : any_offset();
        zr   = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
        begin
            nb = 8'($urandom);
            case ($urandom_range(0, 3))
                0, 1:    ob = nb;
                2:       ob = 8'h00;
                default: ob = 8'($urandom);
            endcase
            queue_byte(base + OFF_W'(i), nb, ob, zr, i == len - 1);
        end
    endtask

    // single: only forms that take at most one table entry, so the fill
    // level walks through every count near the top.
    task automatic queue_random_range(input logic single);
        logic [1:0]       op;
        logic [OFF_W-1:0] lo;
        logic [OFF_W-1:0] hi;
        logic [OFF_W-1:0] tmp;
        if (single)
        begin
            if ($urandom_range(0, 1))
            begin
                op = CMD_ADD;
                lo = pick_base();
                hi = lo + OFF_W'($urandom_range(0, 64));
            end
            else
            begin
                // complement with start 0: only the upper entry is needed
                op = CMD_COMP;
                lo = '0;
                hi = TOP_OFFSET - OFF_W'(1) - OFF_W'($urandom_range(0, 1 << 20));
            end
        end
        else
        begin
            op = $urandom_range(0, 1) ? CMD_COMP : CMD_ADD;
            lo = pick_base();
            hi = ($urandom_range(0, 9) == 0) ? any_offset()
                                             : lo + OFF_W'($urandom_range(0, 64));
            case ($urandom_range(0, 9))
                0: lo = '0;
                1: hi = TOP_OFFSET;
                2:
                begin
                    lo = '0;
                    hi = TOP_OFFSET;
                end
                3:
                begin
                    // swapped ends, normally an inverted range
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                default: ;
            endcase
        end
        queue_range(op, lo, hi);
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    initial
    begin : run_stimulus
        int   n_start;
        int   roll;
        int   adds_left;
        logic single;
        logic probe_done;
        probe_done = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // check with an empty table: nothing is protected
        queue_byte(TOP_OFFSET, 8'hFF, 8'h00, 1'b0, 1'b1);
        // inverted range, both add forms
        queue_range(CMD_ADD, 63'd5, 63'd4);
        queue_range(CMD_COMP, TOP_OFFSET, '0);
        // complement of everything: no entries needed
        queue_range(CMD_COMP, '0, TOP_OFFSET);
        // extreme single-byte ranges
        queue_range(CMD_ADD, '0, '0);
        queue_range(CMD_ADD, TOP_OFFSET, TOP_OFFSET);
        // adjacent and overlapping ranges
        queue_range(CMD_ADD, 63'd100, 63'd199);
        queue_range(CMD_ADD, 63'd200, 63'd299);
        queue_range(CMD_ADD, 63'd150, 63'd250);
        // unused command code, all ones
        queue_req(CMD_UNUSED, TOP_OFFSET, TOP_OFFSET, TOP_OFFSET, 8'hFF, 8'hFF, 1'b1, 1'b1);
        // multi-byte write: first offender is 200, later ones don't move it
        queue_byte(63'd99, 8'h11, 8'h22, 1'b0, 1'b0);
        queue_byte(63'd100, 8'hFF, 8'hFF, 1'b0, 1'b0);
        queue_byte(63'd200, 8'h00, 8'hFF, 1'b0, 1'b0);
        queue_byte(63'd250, 8'h01, 8'h02, 1'b0, 1'b0);
        queue_byte(63'd300, 8'h01, 8'h02, 1'b0, 1'b1);
        // verdict is cleared: zeroing an already-zero byte at offset 0
        queue_byte('0, 8'hFF, 8'h00, 1'b1, 1'b1);
        // zeroing a non-zero protected byte at the top offset
        queue_byte(TOP_OFFSET, 8'h00, 8'h5A, 1'b1, 1'b1);
        // zeroing ignores new_byte
        queue_byte(63'd150, 8'h33, 8'h00, 1'b1, 1'b1);
        // complement needing both entries
        queue_range(CMD_COMP, 63'd1000, TOP_OFFSET - OFF_W'(1));
        queue_byte(63'd500, 8'h00, 8'h80, 1'b0, 1'b1);
        queue_byte(63'd1000, 8'h00, 8'h80, 1'b0, 1'b1);
        while (pend_q.size() != 0 || armed || start)
            @(posedge clk);

        // --- random part ---
        for (int chunk = 0; chunk < N_CHUNKS; chunk++)
        begin
            // mostly random gaps, some chunks back to back
            idle_on = ($urandom_range(0, 3) != 0);
            // one slot left: a two-entry complement must be refused
            if (prot_cnt == MAX_RANGES - 1 && !probe_done)
            begin
                queue_range(CMD_COMP, 63'd1 + OFF_W'($urandom_range(0, 1000)),
                            TOP_OFFSET - OFF_W'(1) - OFF_W'($urandom_range(0, 1000)));
                probe_done = 1'b1;
            end
            single    = (prot_cnt >= MAX_RANGES - 6 && prot_cnt < MAX_RANGES);
            adds_left = single ? 1 : 3;
            n_start   = n_queued;
            while (n_queued - n_start < CHUNK_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8 && adds_left > 0)
                begin
                    queue_random_range(single);
                    adds_left--;
                end
                else if (roll < 14)
                    // stray byte: may leave a request open or end one early
                    queue_byte(($urandom_range(0, 1) ? near_hot() : any_offset()),
                               8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                else if (roll < 16)
                    queue_req(CMD_UNUSED, any_offset(), any_offset(), any_offset(),
                              8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                else
                    queue_write(($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                             : $urandom_range(9, 40));
            end
            while (pend_q.size() != 0 || armed || start)
                @(posedge clk);
        end

        // drain, then give a slow lookup time to surface a stray result
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_RANGES + 8) @(posedge clk);

        if (outcomes_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));

        $display("Covered %0d requests: %0d range loads (%0d refused as full), %0d write bytes.",
                 n_sent, n_loads, n_full, n_bytes);
        $display("Checked %0d results, %0d of them denied writes; %0d mismatches.",
                 n_checked, n_denied, mismatches);
        if (mismatches == 0)
            $display("protected_range_write_checker regression: pass");
        else
            $display("protected_range_write_checker regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("Timeout: stimulus or results stuck");
        $display("protected_range_write_checker regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/prw_pkg.sv
rtl/core/prw_cell.sv
rtl/core/protected_range_write_checker.sv
tb/sv/testbench.sv
